// ===== src/iqs_pkg.sv =====
// Package for the indexed queue store: request and response word types,
// request kinds, status codes and the sequencer state type.
// No dependencies.
package iqs_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_READ   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2,
    STS_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] payload;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } rsp_t;

endpackage

// ===== src/indexed_queue_store_unit.sv =====
// Indexed queue store: ordered queue with push, read at position and remove.
// Push and flagged requests raise out_valid via the DONE state after acceptance, a read
// via LOOKUP and DONE. Remove at position p goes via LOOKUP, then moves each entry after p
// down one place, one entry moving per cycle, then DONE. The next request is accepted in the
// same cycle as out_valid rises; a finished word waits while an earlier word is held by out_ready low.
// Synchronous active-low reset empties the queue; entry contents are left as they are.
module indexed_queue_store_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iqs_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output iqs_pkg::rsp_t out_data
);
  import iqs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  iqs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iqs_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== src/iqs_mem.sv =====
// Entry store of the indexed queue: one write port and one read port,
// read data registered. Depends on nothing.
module iqs_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/iqs_ctrl.sv =====
// Sequencer of the indexed queue: fill count, request decode, the shift loop
// that closes the gap after a remove, and the result register.
// Depends on iqs_pkg; drives the ports of iqs_mem.
module iqs_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  iqs_pkg::req_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output iqs_pkg::rsp_t            out_data,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [DATA_WIDTH-1:0]    mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [DATA_WIDTH-1:0]    mem_rdata
);
  import iqs_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = CNT_W + 1;
  localparam int PW    = (CNT_W > 4) ? CNT_W : 4;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  req_kind_t          kind_r, kind_nxt;
  logic [31:0]        data_r, data_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  rsp_t               out_data_r, out_data_nxt;
  req_kind_t          in_kind;
  logic               accept;
  logic               pos_bad;
  logic               full;
  logic               more1;
  logic               more2;

  assign in_kind = req_kind_t'(in_data.req_type);
  assign accept  = in_valid && in_ready;
  assign pos_bad = PW'(in_data.position) >= PW'(cnt_r);
  assign full    = cnt_r == CNT_W'(DEPTH);
  assign more1   = (XW'(idx_r) + XW'(1)) < XW'(cnt_r);
  assign more2   = (XW'(idx_r) + XW'(2)) < XW'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    data_nxt      = data_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          idx_nxt    = AW'(in_data.position);
          data_nxt   = '0;
          status_nxt = STS_OK;
          state_nxt  = ST_DONE;
          case (in_kind)
            REQ_PUSH: begin
              if (full) begin
                status_nxt = STS_FULL;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            REQ_READ, REQ_REMOVE: begin
              if (pos_bad) begin
                status_nxt = STS_BAD_POS;
              end else begin
                state_nxt = ST_LOOKUP;
              end
            end
            default: begin
              status_nxt = STS_OK;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        data_nxt  = 32'(mem_rdata);
        state_nxt = ST_DONE;
        if (kind_r == REQ_REMOVE) begin
          if (more1) begin
            state_nxt = ST_SHIFT;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      ST_SHIFT: begin
        idx_nxt = idx_r + AW'(1);
        if (!more2) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = data_r;
          out_data_nxt.status    = status_r;
          out_data_nxt.occupancy = 5'(cnt_r);
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = state_r == ST_IDLE;
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt_r);
    mem_wdata = DATA_WIDTH'(in_data.payload);
    mem_raddr = AW'(in_data.position);
    case (state_r)
      ST_IDLE: begin
        mem_we = accept && (in_kind == REQ_PUSH) && !full;
      end
      ST_LOOKUP: begin
        mem_raddr = idx_r + AW'(1);
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        mem_raddr = idx_r + AW'(2);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    kind_r     <= kind_nxt;
    data_r     <= data_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) <= XW'(DEPTH))
    else $error("fill count above depth");

  a_shift_remove: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> kind_r == REQ_REMOVE && more1)
    else $error("shift loop outside a remove");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == REQ_PUSH && !full |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not grow the queue");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_IDLE || state_r == ST_SHIFT)
    else $error("entry write in a state without one");

endmodule
